/* design/lmss_pkg.sv */
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types, codes and reset contents for the LED matrix scan scroller.
// ----------------------------------------------------------------------------
package lmss_pkg;

  localparam int unsigned ROWS_DEFAULT   = 8;
  localparam int unsigned PATTERN_W      = 48;
  localparam int unsigned COLUMN_W       = 16;
  localparam int unsigned PERIOD_W       = 16;
  localparam int unsigned HSTEP_W        = 7;
  localparam int unsigned VSTEP_W        = 5;
  localparam int unsigned CFG_INDEX_W    = 1;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [VSTEP_W-1:0]  VSTEP_LAST     = VSTEP_W'(29);
  localparam logic [HSTEP_W-1:0]  HSHIFT_SPAN    = HSTEP_W'(64);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(100);

  typedef logic [PATTERN_W-1:0] pattern_row_t;
  typedef logic [COLUMN_W-1:0]  column_word_t;

  // scroll modes
  localparam logic [1:0] MODE_LEFT  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_UP    = 2'd2;
  localparam logic [1:0] MODE_DOWN  = 2'd3;

  // request ops
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = CFG_INDEX_W'(1);

  // digit glyphs 0..5, last row blank
  localparam pattern_row_t GLYPH_ROWS [ROWS_DEFAULT] = '{
    48'h3c103c3c087e, 48'h423042421840, 48'h46500202287c,
    48'h4a100c1c4802, 48'h52103002fe02, 48'h621042420842,
    48'h3c7c7e3c1c3c, 48'h000000000000
  };

endpackage

/* design/lmss_frame_build.sv */
// ----------------------------------------------------------------------------
// lmss_frame_build
// Computes all frame rows for the current scroll mode and step in one pass.
// ----------------------------------------------------------------------------
module lmss_frame_build #(
  parameter int unsigned ROWS = lmss_pkg::ROWS_DEFAULT
) (
  input  logic [1:0]                        mode_i,
  input  logic [lmss_pkg::HSTEP_W-1:0]      hstep_i,
  input  logic [lmss_pkg::VSTEP_W-1:0]      vstep_i,
  input  lmss_pkg::pattern_row_t            pattern_i [ROWS],
  output lmss_pkg::column_word_t            frame_o   [ROWS]
);

  localparam int unsigned RowW = $clog2(ROWS);

  logic                            shift_right;
  logic                            below_span;
  logic [lmss_pkg::HSTEP_W-1:0]    shamt;

  assign below_span  = (hstep_i < lmss_pkg::HSHIFT_SPAN);
  assign shift_right = (mode_i == lmss_pkg::MODE_LEFT) == below_span;
  assign shamt       = below_span ? (lmss_pkg::HSHIFT_SPAN - hstep_i)
                                  : (hstep_i - lmss_pkg::HSHIFT_SPAN);

  always_comb begin
    logic [63:0]                   wide;
    logic [63:0]                   shifted;
    logic [5:0]                    line;
    logic [RowW-1:0]               src;
    lmss_pkg::pattern_row_t        prow;
    wide    = '0;
    shifted = '0;
    line    = '0;
    src     = '0;
    prow    = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (mode_i == lmss_pkg::MODE_LEFT || mode_i == lmss_pkg::MODE_RIGHT) begin
        wide    = {16'b0, pattern_i[i]};
        shifted = shift_right ? (wide >> shamt) : (wide << shamt);
        if (shamt[6]) begin
          shifted = '0;
        end
        frame_o[i] = shifted[15:0];
      end else begin
        // strip line index biased by eight, so it never goes negative
        if (mode_i == lmss_pkg::MODE_UP) begin
          line = 6'(i) + {1'b0, vstep_i} + 6'd1;
        end else begin
          line = 6'd31 + 6'(i) - {1'b0, vstep_i};
        end
        src  = line[RowW-1:0];
        prow = pattern_i[src];
        case (line[5:3])
          3'd1:    frame_o[i] = prow[47:32];
          3'd2:    frame_o[i] = prow[31:16];
          3'd3:    frame_o[i] = prow[15:0];
          default: frame_o[i] = '0;
        endcase
      end
    end
  end

endmodule

/* design/led_matrix_scan_scroller_unit.sv */
// ----------------------------------------------------------------------------
// led_matrix_scan_scroller_unit
// Scans an 8x16 LED matrix from a scrolling frame built from a pattern store.
// ----------------------------------------------------------------------------
// Path: a tick request's result passes the input register, then the result
// register; loads give no result.
// Throughput: one request per cycle, unless a tick waits behind an untaken
// result; the combinational frame rebuild logic feeds the frame register.
// Reset: pattern holds digit glyphs 0..5, frame cleared, counters at zero,
// mode scroll up, period 100.
module led_matrix_scan_scroller_unit #(
  parameter int unsigned ROWS = lmss_pkg::ROWS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lmss_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [lmss_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [$clog2(ROWS)-1:0]              pattern_row_i,
  input  logic [lmss_pkg::PATTERN_W-1:0]       pattern_bits_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ROWS-1:0]                      row_drive_n_o,
  output logic [lmss_pkg::COLUMN_W-1:0]        column_data_o
);

  localparam int unsigned RowW = $clog2(ROWS);

  logic [1:0]                           mode_q;
  logic [lmss_pkg::PERIOD_W-1:0]        period_q;

  logic                                 s1_valid_q;
  logic                                 s1_op_q;
  logic [RowW-1:0]                      s1_row_q;
  lmss_pkg::pattern_row_t               s1_bits_q;
  logic                                 s1_adv;

  lmss_pkg::pattern_row_t               pattern_q [ROWS];
  lmss_pkg::column_word_t               frame_q   [ROWS];
  lmss_pkg::column_word_t               frame_new [ROWS];
  logic [RowW-1:0]                      scan_row_q;
  logic [lmss_pkg::PERIOD_W-1:0]        tick_q;
  logic [lmss_pkg::PERIOD_W-1:0]        tick_d;
  logic [lmss_pkg::HSTEP_W-1:0]         hstep_q;
  logic [lmss_pkg::VSTEP_W-1:0]         vstep_q;

  logic                                 out_valid_q;
  logic [ROWS-1:0]                      row_drive_q;
  lmss_pkg::column_word_t               column_q;

  logic                                 do_tick;
  logic                                 do_load;
  logic                                 rebuild;
  logic                                 horiz;

  assign s1_adv     = s1_valid_q &&
                      (s1_op_q == lmss_pkg::OP_LOAD || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign do_tick    = s1_adv && (s1_op_q == lmss_pkg::OP_TICK);
  assign do_load    = s1_adv && (s1_op_q == lmss_pkg::OP_LOAD);
  assign tick_d     = tick_q + 1'b1;
  assign rebuild    = do_tick && (tick_d == period_q);
  assign horiz      = (mode_q == lmss_pkg::MODE_LEFT) || (mode_q == lmss_pkg::MODE_RIGHT);

  lmss_frame_build #(
    .ROWS (ROWS)
  ) u_frame_build (
    .mode_i    (mode_q),
    .hstep_i   (hstep_q),
    .vstep_i   (vstep_q),
    .pattern_i (pattern_q),
    .frame_o   (frame_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lmss_pkg::MODE_UP;
      period_q <= lmss_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lmss_pkg::CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        lmss_pkg::CFG_PERIOD: period_q <= cfg_data_i[lmss_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q   <= op_i;
      s1_row_q  <= pattern_row_i;
      s1_bits_q <= pattern_bits_i;
    end
  end

  // pattern and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        pattern_q[r] <= lmss_pkg::GLYPH_ROWS[r];
        frame_q[r]   <= '0;
      end
    end else begin
      if (do_load) begin
        pattern_q[s1_row_q] <= s1_bits_q;
      end
      if (rebuild) begin
        for (int r = 0; r < ROWS; r++) begin
          frame_q[r] <= frame_new[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      tick_q     <= '0;
      hstep_q    <= '0;
      vstep_q    <= '0;
    end else if (do_tick) begin
      scan_row_q <= scan_row_q + 1'b1;
      tick_q     <= rebuild ? '0 : tick_d;
      if (rebuild && horiz) begin
        hstep_q <= hstep_q + 1'b1;
      end
      if (rebuild && !horiz) begin
        vstep_q <= (vstep_q >= lmss_pkg::VSTEP_LAST) ? '0 : vstep_q + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      row_drive_q <= ~(ROWS'(1) << scan_row_q);
      column_q    <= frame_q[scan_row_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_drive_n_o = row_drive_q;
  assign column_data_o = column_q;

endmodule

/* tb/sv/led_matrix_scan_scroller_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scan_scroller_unit_tb
// Self-checking bench for the LED matrix scan scroller. A directed table
// covers reset state, pattern extremes and all four scroll modes. Random
// phases of ticks and pattern loads follow, run under varied mode, period
// and handshake stalls. A short run under the widest period follows. Each
// result is checked against its table word or a cycle-free scanner model.
// ----------------------------------------------------------------------------
module led_matrix_scan_scroller_unit_tb;

  localparam int unsigned NROWS       = lmss_pkg::ROWS_DEFAULT;
  localparam int unsigned PIPE_LAT    = 2;
  localparam int unsigned PHASES      = 16;
  localparam int unsigned PHASE_REQS  = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SLOW_PERIOD = 65535;
  localparam int          STRIP_LINES = 24;

  typedef struct packed {
    logic [NROWS-1:0]       drive_n;
    lmss_pkg::column_word_t column;
  } scan_word_t;

  typedef enum logic [1:0] {DIR_TICK, DIR_LOAD, DIR_CFG} dir_kind_e;

  typedef struct packed {
    dir_kind_e                      kind;
    logic [2:0]                     sel;
    logic [lmss_pkg::PATTERN_W-1:0] value;
    logic                           typed;
    scan_word_t                     word;
  } dir_row_t;

  logic                             clk_i;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_we_i       = 1'b0;
  logic [lmss_pkg::CFG_INDEX_W-1:0] cfg_index_i    = '0;
  logic [lmss_pkg::CFG_DATA_W-1:0]  cfg_data_i     = '0;
  logic                             in_valid_i     = 1'b0;
  logic                             in_ready_o;
  logic                             op_i           = lmss_pkg::OP_TICK;
  logic [2:0]                       pattern_row_i  = '0;
  logic [lmss_pkg::PATTERN_W-1:0]   pattern_bits_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i    = 1'b0;
  logic [NROWS-1:0]                 row_drive_n_o;
  lmss_pkg::column_word_t           column_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;

  scan_word_t scan_outputs_q[$];

  // scanner model state
  lmss_pkg::pattern_row_t        pat_mem   [NROWS];
  lmss_pkg::column_word_t        frame_mem [NROWS];
  logic [2:0]                    row_ptr;
  logic [lmss_pkg::PERIOD_W-1:0] tick_cnt;
  logic [lmss_pkg::PERIOD_W-1:0] period_q;
  logic [lmss_pkg::HSTEP_W-1:0]  hpos;
  logic [lmss_pkg::VSTEP_W-1:0]  vpos;
  logic [1:0]                    mode_q;

  dir_row_t directed_rows [33] = '{
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hFE, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hFD, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hFB, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hF7, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hEF, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hDF, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hBF, 16'h0000}},
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'h7F, 16'h0000}},
    '{DIR_LOAD, 3'd0, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{DIR_LOAD, 3'd7, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{DIR_LOAD, 3'd3, 48'h8000_0000_0001, 1'b0, '0},
    '{DIR_LOAD, 3'd6, 48'h0000_0000_0000, 1'b0, '0},
    '{DIR_CFG,  3'(lmss_pkg::CFG_PERIOD), 48'd9, 1'b0, '0},
    // count reaches the period here; old frame still shown
    '{DIR_TICK, 3'd0, 48'd0, 1'b1, '{8'hFE, 16'h0000}},
    '{DIR_CFG,  3'(lmss_pkg::CFG_PERIOD), 48'd1, 1'b0, '0},
    // first horizontal rebuild shifts by 64
    '{DIR_CFG,  3'(lmss_pkg::CFG_MODE), 48'(lmss_pkg::MODE_LEFT), 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_CFG,  3'(lmss_pkg::CFG_MODE), 48'(lmss_pkg::MODE_RIGHT), 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_CFG,  3'(lmss_pkg::CFG_MODE), 48'(lmss_pkg::MODE_DOWN), 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_LOAD, 3'd5, 48'h5555_AAAA_0F0F, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_CFG,  3'(lmss_pkg::CFG_MODE), 48'(lmss_pkg::MODE_UP), 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0},
    '{DIR_TICK, 3'd0, 48'd0, 1'b0, '0}
  };

  led_matrix_scan_scroller_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .pattern_row_i  (pattern_row_i),
    .pattern_bits_i (pattern_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_drive_n_o  (row_drive_n_o),
    .column_data_o  (column_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic lmss_pkg::column_word_t strip_slice(int n);
    if (n < 0 || n >= STRIP_LINES) return '0;
    if (n < 8) return pat_mem[n][47:32];
    if (n < 16) return pat_mem[n-8][31:16];
    return pat_mem[n-16][15:0];
  endfunction

  function automatic void rebuild_frame_model();
    logic [63:0] wide;
    logic [63:0] shifted;
    int          amt;
    int          lnum;
    for (int i = 0; i < NROWS; i++) begin
      if (mode_q == lmss_pkg::MODE_LEFT || mode_q == lmss_pkg::MODE_RIGHT) begin
        wide = 64'(pat_mem[i]);
        if (hpos < lmss_pkg::HSHIFT_SPAN) begin
          amt = 64 - int'(hpos);
          shifted = (mode_q == lmss_pkg::MODE_LEFT) ? (wide >> amt) : (wide << amt);
        end else begin
          amt = int'(hpos) - 64;
          shifted = (mode_q == lmss_pkg::MODE_LEFT) ? (wide << amt) : (wide >> amt);
        end
        if (amt >= 64) shifted = '0;
        frame_mem[i] = shifted[15:0];
      end else begin
        lnum = (mode_q == lmss_pkg::MODE_UP) ? i + int'(vpos) - 7 : 23 + i - int'(vpos);
        frame_mem[i] = strip_slice(lnum);
      end
    end
    if (mode_q == lmss_pkg::MODE_LEFT || mode_q == lmss_pkg::MODE_RIGHT) begin
      hpos = hpos + 1'b1;
    end else begin
      vpos = (vpos == lmss_pkg::VSTEP_LAST) ? '0 : vpos + 1'b1;
    end
  endfunction

  function automatic bit model_request(input logic op, input logic [2:0] prow,
                                       input lmss_pkg::pattern_row_t pbits,
                                       output scan_word_t word);
    word = '0;
    if (op == lmss_pkg::OP_LOAD) begin
      pat_mem[prow] = pbits;
      return 1'b0;
    end
    word.drive_n = ~(NROWS'(1) << row_ptr);
    word.column  = frame_mem[row_ptr];
    row_ptr  = row_ptr + 1'b1;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt == period_q) begin
      tick_cnt = '0;
      rebuild_frame_model();
    end
    return 1'b1;
  endfunction

  function automatic void report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic lmss_pkg::pattern_row_t random_pattern();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      default: return lmss_pkg::PATTERN_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [lmss_pkg::PERIOD_W-1:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return lmss_pkg::PERIOD_W'(1);
    if (roll < 85) return lmss_pkg::PERIOD_W'($urandom_range(4, 2));
    return lmss_pkg::PERIOD_W'($urandom_range(40, 5));
  endfunction

  task automatic check_result();
    scan_word_t want;
    if (scan_outputs_q.size() == 0) begin
      report_error($sformatf("unexpected result drive_n=%h column=%h",
                             row_drive_n_o, column_data_o));
    end else begin
      want = scan_outputs_q.pop_front();
      if (row_drive_n_o !== want.drive_n)
        report_error($sformatf("row_drive_n exp %h got %h", want.drive_n, row_drive_n_o));
      if (column_data_o !== want.column)
        report_error($sformatf("column_data exp %h got %h", want.column, column_data_o));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic op, input logic [2:0] prow,
                              input lmss_pkg::pattern_row_t pbits,
                              input bit typed, input scan_word_t typed_word);
    scan_word_t word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    pattern_row_i  <= prow;
    pattern_bits_i <= pbits;
    do @(posedge clk_i); while (!in_ready_o);
    if (model_request(op, prow, pbits, word)) scan_outputs_q.push_back(typed ? typed_word : word);
  endtask

  // loads leave nothing to wait on, so allow the pipe to empty too
  task automatic settle();
    in_valid_i <= 1'b0;
    while (scan_outputs_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 3) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [lmss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lmss_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == lmss_pkg::CFG_MODE) mode_q = data[1:0];
    else period_q = data;
  endtask

  initial begin
    logic [1:0]                    next_mode;
    logic [lmss_pkg::PERIOD_W-1:0] next_period;
    logic                          op;

    foreach (pat_mem[i]) pat_mem[i] = lmss_pkg::GLYPH_ROWS[i];
    foreach (frame_mem[i]) frame_mem[i] = '0;
    row_ptr  = '0;
    tick_cnt = '0;
    hpos     = '0;
    vpos     = '0;
    mode_q   = lmss_pkg::MODE_UP;
    period_q = lmss_pkg::PERIOD_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      case (directed_rows[k].kind)
        DIR_CFG: begin
          settle();
          write_cfg(directed_rows[k].sel[lmss_pkg::CFG_INDEX_W-1:0],
                    directed_rows[k].value[lmss_pkg::CFG_DATA_W-1:0]);
        end
        DIR_LOAD: send_request(lmss_pkg::OP_LOAD, directed_rows[k].sel,
                               directed_rows[k].value,
                               directed_rows[k].typed, directed_rows[k].word);
        default: send_request(lmss_pkg::OP_TICK, 3'($urandom_range(7)), random_pattern(),
                              directed_rows[k].typed, directed_rows[k].word);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      settle();
      next_mode   = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
      next_period = pick_period();
      // run the count back to zero so the new period matches soon
      while (tick_cnt >= next_period)
        send_request(lmss_pkg::OP_TICK, 3'($urandom_range(7)), random_pattern(), 1'b0, '0);
      settle();
      write_cfg(lmss_pkg::CFG_MODE, {14'($urandom), next_mode});
      write_cfg(lmss_pkg::CFG_PERIOD, next_period);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (ph == 5 && n == PHASE_REQS / 2) settle();
        op = ($urandom_range(99) < 20) ? lmss_pkg::OP_LOAD : lmss_pkg::OP_TICK;
        send_request(op, 3'($urandom_range(7)), random_pattern(), 1'b0, '0);
      end
    end

    // widest period: the count climbs without a match
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_cfg(lmss_pkg::CFG_PERIOD, lmss_pkg::PERIOD_W'(SLOW_PERIOD));
    for (int n = 0; n < 32; n++)
      send_request(lmss_pkg::OP_TICK, 3'($urandom_range(7)), random_pattern(), 1'b0, '0);

    settle();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    write_cfg(lmss_pkg::CFG_MODE, {14'($urandom), 2'($urandom_range(3))});
    write_cfg(lmss_pkg::CFG_PERIOD, lmss_pkg::PERIOD_W'(1));
    for (int n = 0; n < 32; n++) begin
      op = ($urandom_range(99) < 20) ? lmss_pkg::OP_LOAD : lmss_pkg::OP_TICK;
      send_request(op, 3'($urandom_range(7)), random_pattern(), 1'b0, '0);
    end

    settle();
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
design/lmss_pkg.sv
design/lmss_frame_build.sv
design/led_matrix_scan_scroller_unit.sv
tb/sv/led_matrix_scan_scroller_unit_tb.sv
